/* sv/pirc_pkg.sv */
// Shared types, widths, register indexes and helpers for the rotated capsule point test.
// No dependencies; used by every module of the block.
package pirc_pkg;

    // Field and register widths
    localparam int COORD_W    = 24;
    localparam int SIDE_W     = 23;
    localparam int ROT_W      = 16;
    localparam int ROT_SHIFT  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTED   = 3'd6;

    localparam logic signed [ROT_W-1:0] ROT_COS_RESET = 16'sd16384;

    // Squared half segment length at or below this is treated as a single point
    localparam int DEGENERATE_EPS = 7;

    // Input hold-off count after a register write; the geometry pipeline is nine deep
    localparam int SETTLE_CYCLES = 10;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    // Internal widths, lengths in doubled units
    localparam int DBL_W   = 26;   // box centre, rotated half segment
    localparam int MX_W    = 40;   // rotation product, Q26.14
    localparam int AX_W    = 27;   // endpoint A
    localparam int DD_W    = 27;   // full segment vector
    localparam int RR_W    = 46;   // squared radius
    localparam int ESQ_W   = 52;   // squared half segment component
    localparam int SEG2_W  = 50;   // squared half segment length
    localparam int DDSQ_W  = 52;   // squared full segment length
    localparam int PPROD_W = 48;   // partial products of r^2 * seg^2
    localparam int PSUM_W  = 74;
    localparam int CSQ_W   = 108;  // squared cross product and its bound

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic        [SIDE_W-1:0]  box_width;
        logic        [SIDE_W-1:0]  box_height;
        logic signed [ROT_W-1:0]   rot_cos;
        logic signed [ROT_W-1:0]   rot_sin;
        logic                      oriented;
    } cfg_t;

    typedef struct packed {
        logic signed [AX_W-1:0] ax;
        logic signed [AX_W-1:0] ay;
        logic signed [DD_W-1:0] ddx;
        logic signed [DD_W-1:0] ddy;
        logic        [DDSQ_W-1:0] dd;
        logic        [RR_W-1:0]   rr;
        logic        [CSQ_W-1:0]  rrdd;
        logic                     degen;
    } geom_t;

    // Drop 14 fraction bits, rounding half away from zero
    function automatic logic signed [DBL_W-1:0] rot_round(input logic signed [MX_W-1:0] v);
        logic [MX_W-1:0] mag;
        logic [MX_W-1:0] r;
        logic signed [DBL_W-1:0] rs;
        mag = v[MX_W-1] ? MX_W'(-v) : MX_W'(v);
        r   = (mag + (MX_W'(1) << (ROT_SHIFT - 1))) >> ROT_SHIFT;
        rs  = DBL_W'(r);
        return v[MX_W-1] ? -rs : rs;
    endfunction

endpackage

/* sv/pirc_cfg.sv */
// Configuration register file and settle counter for the capsule test.
// Depends on pirc_pkg.
module pirc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pirc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pirc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output pirc_pkg::cfg_t                      cfg,
    output logic                                settled
);

    pirc_pkg::cfg_t cfg_reg;
    pirc_pkg::cfg_t cfg_next;
    logic [pirc_pkg::SETTLE_W-1:0] settle_reg;
    logic [pirc_pkg::SETTLE_W-1:0] settle_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pirc_pkg::REG_ORIGIN_X:
                    cfg_next.origin_x = cfg_data[pirc_pkg::COORD_W-1:0];
                pirc_pkg::REG_ORIGIN_Y:
                    cfg_next.origin_y = cfg_data[pirc_pkg::COORD_W-1:0];
                pirc_pkg::REG_BOX_WIDTH:
                    cfg_next.box_width = cfg_data[pirc_pkg::SIDE_W-1:0];
                pirc_pkg::REG_BOX_HEIGHT:
                    cfg_next.box_height = cfg_data[pirc_pkg::SIDE_W-1:0];
                pirc_pkg::REG_ROT_COS:
                    cfg_next.rot_cos = cfg_data[pirc_pkg::ROT_W-1:0];
                pirc_pkg::REG_ROT_SIN:
                    cfg_next.rot_sin = cfg_data[pirc_pkg::ROT_W-1:0];
                pirc_pkg::REG_ORIENTED:
                    cfg_next.oriented = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Any write, even to an unused index, restarts the settle count
    always_comb
    begin
        if (cfg_we)
            settle_next = pirc_pkg::SETTLE_W'(pirc_pkg::SETTLE_CYCLES);
        else if (settle_reg != '0)
            settle_next = settle_reg - pirc_pkg::SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.box_width  <= '0;
            cfg_reg.box_height <= '0;
            cfg_reg.rot_cos    <= pirc_pkg::ROT_COS_RESET;
            cfg_reg.rot_sin    <= '0;
            cfg_reg.oriented   <= 1'b0;
            settle_reg         <= pirc_pkg::SETTLE_W'(pirc_pkg::SETTLE_CYCLES);
        end
        else
        begin
            cfg_reg    <= cfg_next;
            settle_reg <= settle_next;
        end
    end

    assign cfg     = cfg_reg;
    assign settled = (settle_reg == '0);

endmodule

/* sv/pirc_geom.sv */
// Free-running pipeline that turns the box registers into capsule geometry:
// endpoint A, segment vector, squared radius and the r^2 * |D|^2 bound. Depends on pirc_pkg.
module pirc_geom (
    input  logic            clk,
    input  pirc_pkg::cfg_t  cfg,
    output pirc_pkg::geom_t geom
);

    // stage 1: side compare, centre
    logic                                tall_reg;
    logic        [pirc_pkg::SIDE_W-1:0]  dlen_reg;
    logic        [pirc_pkg::SIDE_W-1:0]  r2_reg;
    logic signed [pirc_pkg::DBL_W-1:0]   cx_reg;
    logic signed [pirc_pkg::DBL_W-1:0]   cy_reg;
    // stage 2: rotation products, squared radius
    logic signed [pirc_pkg::MX_W-1:0]    pc_reg;
    logic signed [pirc_pkg::MX_W-1:0]    ps_reg;
    logic        [pirc_pkg::RR_W-1:0]    rr_reg;
    logic                                tall2_reg;
    logic        [pirc_pkg::SIDE_W-1:0]  dlen2_reg;
    // stage 3: rotated half segment before rounding
    logic signed [pirc_pkg::MX_W-1:0]    mx_reg;
    logic signed [pirc_pkg::MX_W-1:0]    my_reg;
    logic                                tall3_reg;
    logic        [pirc_pkg::SIDE_W-1:0]  dlen3_reg;
    // stage 4: half segment
    logic signed [pirc_pkg::DBL_W-1:0]   ex_reg;
    logic signed [pirc_pkg::DBL_W-1:0]   ey_reg;
    // stage 5: endpoint A, component squares
    logic signed [pirc_pkg::AX_W-1:0]    ax_reg;
    logic signed [pirc_pkg::AX_W-1:0]    ay_reg;
    logic signed [pirc_pkg::DD_W-1:0]    ddx_reg;
    logic signed [pirc_pkg::DD_W-1:0]    ddy_reg;
    logic signed [pirc_pkg::ESQ_W-1:0]   exsq_reg;
    logic signed [pirc_pkg::ESQ_W-1:0]   eysq_reg;
    // stage 6
    logic        [pirc_pkg::SEG2_W-1:0]  seg2_reg;
    // stage 7
    logic                                degen_reg;
    logic        [pirc_pkg::DDSQ_W-1:0]  dd_reg;
    logic        [pirc_pkg::PPROD_W-1:0] p11_reg;
    logic        [pirc_pkg::PPROD_W-1:0] p10_reg;
    logic        [pirc_pkg::PPROD_W-1:0] p01_reg;
    logic        [pirc_pkg::PPROD_W-1:0] p00_reg;
    // stage 8, 9
    logic        [pirc_pkg::PSUM_W-1:0]  thi_reg;
    logic        [pirc_pkg::PSUM_W-1:0]  tlo_reg;
    logic        [pirc_pkg::CSQ_W-1:0]   rrdd_reg;

    localparam int RR_LO_W  = pirc_pkg::RR_W / 2;
    localparam int SEG_LO_W = pirc_pkg::SEG2_W / 2;

    logic                               tall_next;
    logic        [pirc_pkg::SIDE_W-1:0] dlen_next;
    logic        [pirc_pkg::SIDE_W-1:0] r2_next;
    logic signed [pirc_pkg::DBL_W-1:0]  cx_next;
    logic signed [pirc_pkg::DBL_W-1:0]  cy_next;
    logic signed [pirc_pkg::MX_W-1:0]   dlen_s;
    logic signed [pirc_pkg::DBL_W-1:0]  ex_next;
    logic signed [pirc_pkg::DBL_W-1:0]  ey_next;

    always_comb
    begin
        tall_next = (cfg.box_height >= cfg.box_width);
        dlen_next = tall_next ? (cfg.box_height - cfg.box_width)
                              : (cfg.box_width - cfg.box_height);
        r2_next   = tall_next ? cfg.box_width : cfg.box_height;
        cx_next   = (pirc_pkg::DBL_W'(cfg.origin_x) <<< 1)
                  + $signed(pirc_pkg::DBL_W'(cfg.box_width));
        cy_next   = (pirc_pkg::DBL_W'(cfg.origin_y) <<< 1)
                  + $signed(pirc_pkg::DBL_W'(cfg.box_height));
        dlen_s    = $signed(pirc_pkg::MX_W'(dlen_reg));
    end

    // At most one of dx, dy is nonzero, so each rotated component is a single product
    always_comb
    begin
        if (cfg.oriented)
        begin
            ex_next = pirc_pkg::rot_round(mx_reg);
            ey_next = pirc_pkg::rot_round(my_reg);
        end
        else
        begin
            ex_next = tall3_reg ? '0 : $signed(pirc_pkg::DBL_W'(dlen3_reg));
            ey_next = tall3_reg ? $signed(pirc_pkg::DBL_W'(dlen3_reg)) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        tall_reg  <= tall_next;
        dlen_reg  <= dlen_next;
        r2_reg    <= r2_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;

        pc_reg    <= dlen_s * pirc_pkg::MX_W'(cfg.rot_cos);
        ps_reg    <= dlen_s * pirc_pkg::MX_W'(cfg.rot_sin);
        rr_reg    <= pirc_pkg::RR_W'(r2_reg) * pirc_pkg::RR_W'(r2_reg);
        tall2_reg <= tall_reg;
        dlen2_reg <= dlen_reg;

        mx_reg    <= tall2_reg ? -ps_reg : pc_reg;
        my_reg    <= tall2_reg ? pc_reg : ps_reg;
        tall3_reg <= tall2_reg;
        dlen3_reg <= dlen2_reg;

        ex_reg    <= ex_next;
        ey_reg    <= ey_next;

        ax_reg    <= pirc_pkg::AX_W'(cx_reg) - pirc_pkg::AX_W'(ex_reg);
        ay_reg    <= pirc_pkg::AX_W'(cy_reg) - pirc_pkg::AX_W'(ey_reg);
        ddx_reg   <= pirc_pkg::DD_W'(ex_reg) <<< 1;
        ddy_reg   <= pirc_pkg::DD_W'(ey_reg) <<< 1;
        exsq_reg  <= pirc_pkg::ESQ_W'(ex_reg) * pirc_pkg::ESQ_W'(ex_reg);
        eysq_reg  <= pirc_pkg::ESQ_W'(ey_reg) * pirc_pkg::ESQ_W'(ey_reg);

        seg2_reg  <= pirc_pkg::SEG2_W'($unsigned(exsq_reg))
                   + pirc_pkg::SEG2_W'($unsigned(eysq_reg));

        degen_reg <= (seg2_reg <= pirc_pkg::SEG2_W'(pirc_pkg::DEGENERATE_EPS));
        dd_reg    <= pirc_pkg::DDSQ_W'(seg2_reg) << 2;
        // r^2 * seg^2 in four partial products
        p11_reg   <= pirc_pkg::PPROD_W'(rr_reg[pirc_pkg::RR_W-1:RR_LO_W])
                   * pirc_pkg::PPROD_W'(seg2_reg[pirc_pkg::SEG2_W-1:SEG_LO_W]);
        p10_reg   <= pirc_pkg::PPROD_W'(rr_reg[pirc_pkg::RR_W-1:RR_LO_W])
                   * pirc_pkg::PPROD_W'(seg2_reg[SEG_LO_W-1:0]);
        p01_reg   <= pirc_pkg::PPROD_W'(rr_reg[RR_LO_W-1:0])
                   * pirc_pkg::PPROD_W'(seg2_reg[pirc_pkg::SEG2_W-1:SEG_LO_W]);
        p00_reg   <= pirc_pkg::PPROD_W'(rr_reg[RR_LO_W-1:0])
                   * pirc_pkg::PPROD_W'(seg2_reg[SEG_LO_W-1:0]);

        thi_reg   <= (pirc_pkg::PSUM_W'(p11_reg) << SEG_LO_W) + pirc_pkg::PSUM_W'(p10_reg);
        tlo_reg   <= (pirc_pkg::PSUM_W'(p01_reg) << SEG_LO_W) + pirc_pkg::PSUM_W'(p00_reg);

        // |D|^2 = 4 * seg^2
        rrdd_reg  <= ((pirc_pkg::CSQ_W'(thi_reg) << RR_LO_W) + pirc_pkg::CSQ_W'(tlo_reg)) << 2;
    end

    always_comb
    begin
        geom.ax    = ax_reg;
        geom.ay    = ay_reg;
        geom.ddx   = ddx_reg;
        geom.ddy   = ddy_reg;
        geom.dd    = dd_reg;
        geom.rr    = rr_reg;
        geom.rrdd  = rrdd_reg;
        geom.degen = degen_reg;
    end

endmodule

/* sv/pirc_test.sv */
// Nine-stage item pipeline: point offset, products, distance tests and the
// exact cross-product bound compare, with valid bits and per-stage stall. Depends on pirc_pkg.
module pirc_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pirc_pkg::geom_t                     geom,
    input  logic                                settled,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [pirc_pkg::COORD_W-1:0] point_x,
    input  logic signed [pirc_pkg::COORD_W-1:0] point_y,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                inside_res
);

    localparam int NSTAGE = 9;
    localparam int Q_W    = 28;
    localparam int SQ_W   = 2 * Q_W;
    localparam int DOT_W  = 56;
    localparam int B_W    = 29;
    localparam int BSQ_W  = 2 * B_W;
    localparam int PP_W   = SQ_W + 1;
    localparam int PB_W   = BSQ_W + 1;
    localparam int C_W    = 54;
    localparam int CH_W   = C_W / 2;
    localparam int CP_W   = 2 * CH_W;
    localparam int LO_W   = CP_W + CH_W + 2;

    typedef struct packed {
        logic in_a;
        logic in_b;
        logic dot_le0;
        logic dot_ge;
    } flags_t;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE:0]   adv;

    // stage 0
    logic signed [pirc_pkg::COORD_W-1:0] px_reg, py_reg;
    // stage 1
    logic signed [Q_W-1:0]   qx_reg, qy_reg;
    // stage 2
    logic signed [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic signed [DOT_W-1:0] dxx_reg, dyy_reg, dxy_reg, dyx_reg;
    logic signed [B_W-1:0]   bx_reg, by_reg;
    // stage 3
    logic        [PP_W-1:0]  pp_reg;
    logic signed [DOT_W-1:0] dot_reg, cr_reg;
    logic signed [BSQ_W-1:0] bsqx_reg, bsqy_reg;
    // stage 4
    logic        [PB_W-1:0]  pb_reg;
    logic        [C_W-1:0]   c_reg;
    flags_t                  f4_reg;
    // stage 5
    logic        [CP_W-1:0]  c11_reg, c10_reg, c00_reg;
    flags_t                  f5_reg;
    // stage 6
    logic        [CP_W-1:0]  hi_reg;
    logic        [LO_W-1:0]  lo_reg;
    flags_t                  f6_reg;
    // stage 7
    logic        [pirc_pkg::CSQ_W-1:0] csq_reg;
    flags_t                  f7_reg;
    // stage 8: output
    logic                    inside_reg;

    flags_t          f4_next;
    flags_t          f5_next;
    logic [C_W-1:0]  c_next;
    logic            inside_next;

    // A stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[NSTAGE] = m_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k + 1];
    end

    always_comb
    begin
        v_next = v_reg;
        if (adv[0])
            v_next[0] = s_tvalid && settled;
        for (int k = 1; k < NSTAGE; k++)
            if (adv[k])
                v_next[k] = v_reg[k - 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_comb
    begin
        c_next          = cr_reg[DOT_W-1] ? C_W'(-cr_reg) : C_W'(cr_reg);
        f4_next.in_a    = (pp_reg <= PP_W'(geom.rr));
        f4_next.in_b    = 1'b0;
        f4_next.dot_le0 = dot_reg[DOT_W-1] || (dot_reg == '0);
        f4_next.dot_ge  = !dot_reg[DOT_W-1] && ($unsigned(dot_reg) >= DOT_W'(geom.dd));
        f5_next         = f4_reg;
        f5_next.in_b    = (pb_reg <= PB_W'(geom.rr));
        // Degenerate segment and projection before A both use the distance to A
        if (geom.degen || f7_reg.dot_le0)
            inside_next = f7_reg.in_a;
        else if (f7_reg.dot_ge)
            inside_next = f7_reg.in_b;
        else
            inside_next = (csq_reg <= geom.rrdd);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (adv[1])
        begin
            qx_reg <= (Q_W'(px_reg) <<< 1) - Q_W'(geom.ax);
            qy_reg <= (Q_W'(py_reg) <<< 1) - Q_W'(geom.ay);
        end
        if (adv[2])
        begin
            sqx_reg <= SQ_W'(qx_reg) * SQ_W'(qx_reg);
            sqy_reg <= SQ_W'(qy_reg) * SQ_W'(qy_reg);
            dxx_reg <= DOT_W'(qx_reg) * DOT_W'(geom.ddx);
            dyy_reg <= DOT_W'(qy_reg) * DOT_W'(geom.ddy);
            dxy_reg <= DOT_W'(qx_reg) * DOT_W'(geom.ddy);
            dyx_reg <= DOT_W'(qy_reg) * DOT_W'(geom.ddx);
            bx_reg  <= B_W'(qx_reg) - B_W'(geom.ddx);
            by_reg  <= B_W'(qy_reg) - B_W'(geom.ddy);
        end
        if (adv[3])
        begin
            pp_reg   <= PP_W'($unsigned(sqx_reg)) + PP_W'($unsigned(sqy_reg));
            dot_reg  <= dxx_reg + dyy_reg;
            cr_reg   <= dxy_reg - dyx_reg;
            bsqx_reg <= BSQ_W'(bx_reg) * BSQ_W'(bx_reg);
            bsqy_reg <= BSQ_W'(by_reg) * BSQ_W'(by_reg);
        end
        if (adv[4])
        begin
            pb_reg <= PB_W'($unsigned(bsqx_reg)) + PB_W'($unsigned(bsqy_reg));
            c_reg  <= c_next;
            f4_reg <= f4_next;
        end
        if (adv[5])
        begin
            // cross^2 from three half-width products
            c11_reg <= CP_W'(c_reg[C_W-1:CH_W]) * CP_W'(c_reg[C_W-1:CH_W]);
            c10_reg <= CP_W'(c_reg[C_W-1:CH_W]) * CP_W'(c_reg[CH_W-1:0]);
            c00_reg <= CP_W'(c_reg[CH_W-1:0]) * CP_W'(c_reg[CH_W-1:0]);
            f5_reg  <= f5_next;
        end
        if (adv[6])
        begin
            hi_reg <= c11_reg;
            lo_reg <= (LO_W'(c10_reg) << (CH_W + 1)) + LO_W'(c00_reg);
            f6_reg <= f5_reg;
        end
        if (adv[7])
        begin
            csq_reg <= (pirc_pkg::CSQ_W'(hi_reg) << CP_W) + pirc_pkg::CSQ_W'(lo_reg);
            f7_reg  <= f6_reg;
        end
        if (adv[8])
            inside_reg <= inside_next;
    end

    assign s_tready   = adv[0] && settled;
    assign m_tvalid   = v_reg[NSTAGE-1];
    assign inside_res = inside_reg;

endmodule

/* sv/point_in_rotated_capsule_top.sv */
// Top level of the rotated capsule point test: register port, geometry pipeline, item pipeline.
// Depends on pirc_pkg, pirc_cfg, pirc_geom and pirc_test.
//
// Each input item is a point; each yields one output item, 1 when the point lies inside
// the capsule (border included). The block takes one item per clock cycle unless the output
// stalls or the registers are settling; the nine-stage item pipeline has per-stage valid bits,
// and its empty stages fill while a finished result waits at the output. Capsule geometry is
// derived from the registers by a separate nine-stage pipeline, so after reset and after every
// register write s_tready stays low while it refills; write registers only while no item is in
// flight. The inside test is exact: no root, no division.
module point_in_rotated_capsule_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // config write port
    input  logic                                   cfg_we,
    input  logic [pirc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pirc_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pirc_pkg::IN_TDATA_W-1:0]        s_tdata,   // point_x [23:0], point_y [47:24]
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pirc_pkg::OUT_TDATA_W-1:0]       m_tdata    // inside_res [0], zeros above
);

    pirc_pkg::cfg_t  cfg;
    pirc_pkg::geom_t geom;
    logic            settled;
    logic            inside_res;

    pirc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .settled   (settled)
    );

    pirc_geom u_geom (
        .clk  (clk),
        .cfg  (cfg),
        .geom (geom)
    );

    pirc_test u_test (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .settled    (settled),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .point_x    (s_tdata[pirc_pkg::COORD_W-1:0]),
        .point_y    (s_tdata[2*pirc_pkg::COORD_W-1:pirc_pkg::COORD_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .inside_res (inside_res)
    );

    assign m_tdata = {(pirc_pkg::OUT_TDATA_W - 1)'(0), inside_res};

endmodule

/* verif/tb.sv */
// Self-checking testbench for point_in_rotated_capsule_top: directed table, then random shapes.
// Depends on pirc_pkg and the block's RTL; results are checked against a local inside/outside predictor.
module tb;

    localparam logic [pirc_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;  // no register there, write is dropped
    localparam int RAND_ITEMS = 1500;
    localparam int DIR_ROWS   = 45;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 50;

    typedef logic signed [127:0] wide_t;

    typedef enum logic {ROW_REG, ROW_POINT} row_kind_t;
    typedef enum logic [1:0] {WANT_MODEL, WANT_OUT, WANT_IN} want_t;

    typedef struct packed {
        row_kind_t                           kind;
        logic [pirc_pkg::CFG_IDX_W-1:0]      idx;
        logic [pirc_pkg::CFG_DATA_W-1:0]     data;
        logic signed [pirc_pkg::COORD_W-1:0] px;
        logic signed [pirc_pkg::COORD_W-1:0] py;
        want_t                               want;
    } row_t;

    // Points against the reset shape first, then a 1024x512 box at the origin,
    // a zero-height box, a 90 degree turn, a round capsule, a segment below the
    // degenerate bound, a non-unit rotation and finally extreme corners and sides.
    localparam row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd0, 24'sd0, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd1, 24'sd0, WANT_OUT},
        '{ROW_POINT, REG_NONE, 24'h0, -24'sd8388608, 24'sd8388607, WANT_OUT},
        '{ROW_REG, pirc_pkg::REG_BOX_WIDTH, 24'h000400, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_HEIGHT, 24'h000200, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd512, 24'sd256, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd0, 24'sd256, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, -24'sd256, 24'sd256, WANT_OUT},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd1024, 24'sd256, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd1025, 24'sd256, WANT_OUT},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd512, 24'sd512, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd512, 24'sd513, WANT_OUT},
        '{ROW_REG, pirc_pkg::REG_BOX_HEIGHT, 24'h000000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd256, 24'sd0, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd256, 24'sd1, WANT_OUT},
        '{ROW_REG, pirc_pkg::REG_BOX_HEIGHT, 24'h000200, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ROT_COS, 24'h000000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ROT_SIN, 24'h004000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ORIENTED, 24'h000001, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd512, -24'sd256, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd768, 24'sd256, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd769, 24'sd256, WANT_OUT},
        '{ROW_REG, pirc_pkg::REG_ORIENTED, 24'h000000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_WIDTH, 24'h000100, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_HEIGHT, 24'h000100, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd128, 24'sd256, WANT_IN},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd128, 24'sd257, WANT_OUT},
        '{ROW_REG, pirc_pkg::REG_BOX_WIDTH, 24'h000002, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_HEIGHT, 24'h000000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd1, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ROT_COS, 24'h008000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ROT_SIN, 24'h007fff, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ORIENTED, 24'h000001, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_WIDTH, 24'h001000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, REG_NONE, 24'hffffff, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd291, -24'sd1110, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd2048, 24'sd64, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ORIGIN_X, 24'h800000, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_ORIGIN_Y, 24'h7fffff, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_WIDTH, 24'h7fffff, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_REG, pirc_pkg::REG_BOX_HEIGHT, 24'h7fffff, 24'sd0, 24'sd0, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd8388607, -24'sd8388608, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, -24'sd8388608, 24'sd8388607, WANT_MODEL},
        '{ROW_POINT, REG_NONE, 24'h0, 24'sd0, 24'sd0, WANT_MODEL}
    };

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [pirc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [pirc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [pirc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [pirc_pkg::OUT_TDATA_W-1:0] m_tdata;

    pirc_pkg::cfg_t cap_cfg;  // register contents as the block should hold them
    logic inside_exp_q[$];    // expected inside flags, oldest first
    int   fail_count = 0;
    bit   calm = 1'b0;        // sender runs without gaps while set

    point_in_rotated_capsule_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Q2.14 product back to an integer, halves rounded away from zero
    function automatic wide_t q14_round(input wide_t v);
        wide_t m;
        m = (v < 0) ? -v : v;
        m = (m + (wide_t'(1) <<< (pirc_pkg::ROT_SHIFT - 1))) >>> pirc_pkg::ROT_SHIFT;
        return (v < 0) ? -m : m;
    endfunction

    // All lengths in doubled units so the centre and radius are integers
    function automatic logic inside_capsule(input pirc_pkg::cfg_t c,
                                            input logic signed [pirc_pkg::COORD_W-1:0] x,
                                            input logic signed [pirc_pkg::COORD_W-1:0] y);
        wide_t ox, oy, w, h, cs, sn, px, py, r2, rr, cx, cy, dx, dy, ex, ey;
        wide_t qx, qy, pp, seg2, ddx, ddy, dd, dot, bx, by, cr;
        ox = wide_t'(c.origin_x);
        oy = wide_t'(c.origin_y);
        w  = wide_t'(c.box_width);
        h  = wide_t'(c.box_height);
        cs = wide_t'(c.rot_cos);
        sn = wide_t'(c.rot_sin);
        px = wide_t'(x);
        py = wide_t'(y);
        px = 2 * px;
        py = 2 * py;
        r2 = (h >= w) ? w : h;
        rr = r2 * r2;
        cx = 2 * ox + w;
        cy = 2 * oy + h;
        dx = '0;
        dy = '0;
        if (h >= w)
            dy = h - w;
        else
            dx = w - h;
        if (c.oriented)
        begin
            ex = q14_round(dx * cs - dy * sn);
            ey = q14_round(dx * sn + dy * cs);
        end
        else
        begin
            ex = dx;
            ey = dy;
        end
        qx = px - (cx - ex);
        qy = py - (cy - ey);
        pp = qx * qx + qy * qy;
        seg2 = ex * ex + ey * ey;
        if (seg2 <= wide_t'(pirc_pkg::DEGENERATE_EPS))
            return pp <= rr;
        ddx = 2 * ex;
        ddy = 2 * ey;
        dd  = ddx * ddx + ddy * ddy;
        dot = qx * ddx + qy * ddy;
        if (dot <= 0)
            return pp <= rr;
        if (dot >= dd)
        begin
            bx = qx - ddx;
            by = qy - ddy;
            return (bx * bx + by * by) <= rr;
        end
        cr = qx * ddy - qy * ddx;
        return (cr * cr) <= (rr * dd);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 60);
    endfunction

    task automatic write_reg(input logic [pirc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pirc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pirc_pkg::REG_ORIGIN_X:   cap_cfg.origin_x   = data[pirc_pkg::COORD_W-1:0];
            pirc_pkg::REG_ORIGIN_Y:   cap_cfg.origin_y   = data[pirc_pkg::COORD_W-1:0];
            pirc_pkg::REG_BOX_WIDTH:  cap_cfg.box_width  = data[pirc_pkg::SIDE_W-1:0];
            pirc_pkg::REG_BOX_HEIGHT: cap_cfg.box_height = data[pirc_pkg::SIDE_W-1:0];
            pirc_pkg::REG_ROT_COS:    cap_cfg.rot_cos    = data[pirc_pkg::ROT_W-1:0];
            pirc_pkg::REG_ROT_SIN:    cap_cfg.rot_sin    = data[pirc_pkg::ROT_W-1:0];
            pirc_pkg::REG_ORIENTED:   cap_cfg.oriented   = data[0];
            default: ;
        endcase
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (inside_exp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_point(input logic signed [pirc_pkg::COORD_W-1:0] px,
                              input logic signed [pirc_pkg::COORD_W-1:0] py,
                              input want_t want);
        int g;
        if (want == WANT_MODEL)
            inside_exp_q.push_back(inside_capsule(cap_cfg, px, py));
        else
            inside_exp_q.push_back(want == WANT_IN);
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [pirc_pkg::SIDE_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {pirc_pkg::SIDE_W{1'b1}};
            2:       return pirc_pkg::SIDE_W'($urandom);
            default: return pirc_pkg::SIDE_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [pirc_pkg::COORD_W-1:0] pick_origin();
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7fffff;
            2:       return pirc_pkg::COORD_W'($urandom);
            default: return pirc_pkg::COORD_W'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [pirc_pkg::ROT_W-1:0] pick_rot_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h4000;
            1:       return 16'hc000;
            2:       return 16'h8000;
            default: return 16'h7fff;
        endcase
    endfunction

    task automatic load_random_shape();
        pirc_pkg::cfg_t c;
        int   k;
        real  ang;
        c.origin_x   = pick_origin();
        c.origin_y   = pick_origin();
        c.box_width  = pick_side();
        c.box_height = ($urandom_range(0, 9) == 0) ? c.box_width : pick_side();
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
            c.rot_cos = pirc_pkg::ROT_W'($rtoi(16384.0 * $cos(ang)));
            c.rot_sin = pirc_pkg::ROT_W'($rtoi(16384.0 * $sin(ang)));
        end
        else if (k == 6)
        begin
            c.rot_cos = pirc_pkg::ROT_W'($urandom);
            c.rot_sin = pirc_pkg::ROT_W'($urandom);
        end
        else if (k == 7)
        begin
            c.rot_cos = pick_rot_extreme();
            c.rot_sin = pick_rot_extreme();
        end
        else
        begin
            c.rot_cos = pirc_pkg::ROT_COS_RESET;
            c.rot_sin = '0;
        end
        c.oriented = 1'($urandom);
        // junk above a register's width must be dropped by the block
        write_reg(pirc_pkg::REG_ORIGIN_X, c.origin_x);
        write_reg(pirc_pkg::REG_ORIGIN_Y, c.origin_y);
        write_reg(pirc_pkg::REG_BOX_WIDTH, {1'($urandom), c.box_width});
        write_reg(pirc_pkg::REG_BOX_HEIGHT, {1'($urandom), c.box_height});
        write_reg(pirc_pkg::REG_ROT_COS, {8'($urandom), c.rot_cos});
        write_reg(pirc_pkg::REG_ROT_SIN, {8'($urandom), c.rot_sin});
        write_reg(pirc_pkg::REG_ORIENTED, {23'($urandom), c.oriented});
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_NONE, pirc_pkg::CFG_DATA_W'($urandom));
    endtask

    // Mostly points around the box, sized to the box; the rest anywhere
    task automatic send_random_point();
        longint big, lit, span, cxr, cyr, bw, bh;
        logic signed [pirc_pkg::COORD_W-1:0] px, py;
        bw = longint'(cap_cfg.box_width);
        bh = longint'(cap_cfg.box_height);
        big = (bw > bh) ? bw : bh;
        lit = (bw > bh) ? bh : bw;
        span = $urandom_range(0, 1) ? (big * 2 + 8) : (big / 2 + lit / 2 + 4);
        cxr = longint'($signed(cap_cfg.origin_x)) + bw / 2;
        cyr = longint'($signed(cap_cfg.origin_y)) + bh / 2;
        if ($urandom_range(0, 99) < 85)
        begin
            px = pirc_pkg::COORD_W'(cxr + longint'($urandom_range(0, 32'(2 * span))) - span);
            py = pirc_pkg::COORD_W'(cyr + longint'($urandom_range(0, 32'(2 * span))) - span);
        end
        else
        begin
            px = pirc_pkg::COORD_W'($urandom);
            py = pirc_pkg::COORD_W'($urandom);
        end
        send_point(px, py, WANT_MODEL);
    endtask

    // Result side: runs of ready with stalls in between, now and then a long clean run
    initial
    begin
        int run, stall;
        forever
        begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (inside_exp_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $error("inside_res: no item expected, got %0d", m_tdata[0]);
                fail_count++;
            end
            else
            begin
                logic want_in;
                want_in = inside_exp_q.pop_front();
                if (m_tdata[0] !== want_in)
                begin
                    if (fail_count < MAX_REPORTS)
                        $error("inside_res mismatch: expected %0d, got %0d", want_in, m_tdata[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int sent, n;
        cap_cfg = '0;
        cap_cfg.rot_cos = pirc_pkg::ROT_COS_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            end
            else
                send_point(DIR_TAB[i].px, DIR_TAB[i].py, DIR_TAB[i].want);
        end

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            wait_idle();
            load_random_shape();
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(10, 80);
            repeat (n) send_random_point();
            sent += n;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/pirc_pkg.sv
sv/pirc_cfg.sv
sv/pirc_geom.sv
sv/pirc_test.sv
sv/point_in_rotated_capsule_top.sv
verif/tb.sv
